// ----- rtl/iis_pkg.sv -----
`timescale 1ns / 1ps

package iis_pkg;

  // configuration registers are 13 bits wide
  localparam int unsigned RegBits = 13;
  localparam int unsigned CfgIdxBits = 1;

  // row counter covers up to 4096 rows
  localparam int unsigned HeightLimit = 4096;
  localparam int unsigned RowBits = 12;

  localparam logic [RegBits-1:0] WidthReset = 13'd640;
  localparam logic [RegBits-1:0] HeightReset = 13'd480;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_idx_e;

  // position flags of the word being accepted
  typedef struct packed {
    logic first_row;
    logic row_done;
    logic frame_done;
  } pos_flags_t;

endpackage

// ----- rtl/integral_image_stream.sv -----
`timescale 1ns / 1ps

// integral_image_stream: summed-area table over a pixel stream
//
// input channel: one pixel word per raster position, in_valid_i / in_stall_o
// output channel: one area_sum word per pixel, out_valid_o / out_stall_i,
//   frame_end_o marks the word of the last pixel in the frame
// config channel: cfg_valid_i / cfg_ready_o (always ready), index 0 sets
//   frame_width, index 1 sets frame_height; write only while idle
// path: a taken pixel is registered in the ram-read stage and then in the output
//   register, where its word holds while the receiver stalls
// throughput: one pixel per clock while the output is not stalled, set by the single
//   read and single write port of the column-sum ram (read at accept, write-back
//   when the pixel leaves the ram-read stage); reset clears positions, row
//   accumulator and the pipeline; the column-sum ram is not cleared, the first
//   row of each frame never uses its contents; on a receiver stall the output
//   word holds, a pixel may still be taken into an empty ram-read stage, then in_stall_o rises until the word is taken

module integral_image_stream #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned PIXEL_BITS = 8,
  parameter int unsigned SUM_BITS   = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [PIXEL_BITS-1:0]           pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [SUM_BITS-1:0]             area_sum_o,
  output logic                            frame_end_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [iis_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [iis_pkg::RegBits-1:0]     cfg_data_i
);

  localparam int unsigned ColBits = $clog2(MAX_WIDTH);

  logic                 accept;
  logic [ColBits-1:0]   col;
  iis_pkg::pos_flags_t  flags;
  logic [SUM_BITS-1:0]  rd_data;
  logic                 wr_en;
  logic [ColBits-1:0]   wr_addr;
  logic [SUM_BITS-1:0]  wr_data;

  assign cfg_ready_o = 1'b1;

  // column and row tracking, register file
  iis_sched #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (accept),
    .col_o       (col),
    .flags_o     (flags)
  );

  // per-column running sums, read at accept, written back in the next stage
  iis_ram #(
    .Width (SUM_BITS),
    .Depth (MAX_WIDTH)
  ) u_col_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (accept),
    .rd_addr_i (col),
    .rd_data_o (rd_data)
  );

  // column-sum update, row accumulation and output register
  iis_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .col_i       (col),
    .flags_i     (flags),
    .accept_o    (accept),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .area_sum_o  (area_sum_o),
    .frame_end_o (frame_end_o)
  );

  // input only backs up when the output word is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output word");

  // end of row wraps the column position
  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && flags.row_done) |=> (col == '0))
    else $error("column position did not wrap after end of row");

  // end of frame starts the next frame on its first row
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && flags.frame_done) |=> flags.first_row)
    else $error("row position did not wrap after end of frame");

  // a word taken now reaches the output when nothing stalls
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !out_stall_i && !(out_valid_o && out_stall_i)) |=> ##1 out_valid_o)
    else $error("accepted pixel did not reach the output");

endmodule

// ----- rtl/iis_ram.sv -----
`timescale 1ns / 1ps

module iis_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/iis_sched.sv -----
`timescale 1ns / 1ps

module iis_sched #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [iis_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  logic [iis_pkg::RegBits-1:0]          cfg_data_i,
  input  logic                                 advance_i,
  output logic [$clog2(MAX_WIDTH)-1:0]         col_o,
  output iis_pkg::pos_flags_t                  flags_o
);

  localparam int unsigned ColBits = $clog2(MAX_WIDTH);
  localparam int unsigned WBits = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CmpBits = (iis_pkg::RegBits > WBits) ? iis_pkg::RegBits : WBits;
  localparam logic [CmpBits-1:0] WidthTop = CmpBits'(MAX_WIDTH);
  localparam logic [iis_pkg::RegBits-1:0] HeightTop = iis_pkg::RegBits'(iis_pkg::HeightLimit);

  logic [iis_pkg::RegBits-1:0] frame_width_q, frame_height_q;
  logic [ColBits-1:0]          col_q, col_d;
  logic [iis_pkg::RowBits-1:0] row_q, row_d;
  logic [CmpBits-1:0]          width_ext, last_col;
  logic [iis_pkg::RegBits-1:0] last_row;
  logic                        row_done, frame_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= iis_pkg::WidthReset;
      frame_height_q <= iis_pkg::HeightReset;
    end else if (cfg_valid_i) begin
      unique case (iis_pkg::cfg_idx_e'(cfg_index_i))
        iis_pkg::CfgFrameWidth:  frame_width_q  <= cfg_data_i;
        iis_pkg::CfgFrameHeight: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp width to 1..MAX_WIDTH and height to 1..4096
  assign width_ext = CmpBits'(frame_width_q);

  always_comb begin
    priority if (width_ext == '0) begin
      last_col = '0;
    end else if (width_ext > WidthTop) begin
      last_col = WidthTop - CmpBits'(1);
    end else begin
      last_col = width_ext - CmpBits'(1);
    end
  end

  always_comb begin
    priority if (frame_height_q == '0) begin
      last_row = '0;
    end else if (frame_height_q > HeightTop) begin
      last_row = HeightTop - iis_pkg::RegBits'(1);
    end else begin
      last_row = frame_height_q - iis_pkg::RegBits'(1);
    end
  end

  assign row_done   = CmpBits'(col_q) >= last_col;
  assign frame_done = row_done && (iis_pkg::RegBits'(row_q) >= last_row);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (row_done) begin
        col_d = '0;
        row_d = frame_done ? '0 : row_q + iis_pkg::RowBits'(1);
      end else begin
        col_d = col_q + ColBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o              = col_q;
  assign flags_o.first_row  = (row_q == '0);
  assign flags_o.row_done   = row_done;
  assign flags_o.frame_done = frame_done;

endmodule

// ----- rtl/iis_accum.sv -----
`timescale 1ns / 1ps

module iis_accum #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned PIXEL_BITS = 8,
  parameter int unsigned SUM_BITS   = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [PIXEL_BITS-1:0]        pixel_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_i,
  input  iis_pkg::pos_flags_t          flags_i,
  output logic                         accept_o,
  input  logic [SUM_BITS-1:0]          rd_data_i,
  output logic                         wr_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr_o,
  output logic [SUM_BITS-1:0]          wr_data_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [SUM_BITS-1:0]          area_sum_o,
  output logic                         frame_end_o
);

  localparam int unsigned ColBits = $clog2(MAX_WIDTH);

  logic                      s1_valid_q, s1_valid_d;
  logic [PIXEL_BITS-1:0]     s1_pix_q;
  logic [ColBits-1:0]        s1_col_q;
  iis_pkg::pos_flags_t       s1_flags_q;
  logic                      s1_fwd_q;
  logic [SUM_BITS-1:0]       s1_fwd_sum_q;
  logic [SUM_BITS-1:0]       acc_q, acc_d;
  logic                      out_valid_q, out_valid_d;
  logic [SUM_BITS-1:0]       out_sum_q;
  logic                      out_end_q;
  logic                      s1_adv, accept;
  logic [SUM_BITS-1:0]       above, col_sum, acc_sum;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // first row uses zero; same column written back as this pixel was read: take the fresh sum, not the ram
  always_comb begin
    priority if (s1_flags_q.first_row) begin
      above = '0;
    end else if (s1_fwd_q) begin
      above = s1_fwd_sum_q;
    end else begin
      above = rd_data_i;
    end
  end

  assign col_sum = above + SUM_BITS'(s1_pix_q);
  assign acc_sum = acc_q + col_sum;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      s1_valid_d  = 1'b0;
      acc_d       = s1_flags_q.row_done ? '0 : acc_sum;
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q     <= pixel_i;
      s1_col_q     <= col_i;
      s1_flags_q   <= flags_i;
      s1_fwd_q     <= s1_adv && (s1_col_q == col_i);
      s1_fwd_sum_q <= col_sum;
    end
    if (s1_adv) begin
      out_sum_q <= acc_sum;
      out_end_q <= s1_flags_q.frame_done;
    end
  end

  assign accept_o    = accept;
  assign wr_en_o     = s1_adv;
  assign wr_addr_o   = s1_col_q;
  assign wr_data_o   = col_sum;
  assign out_valid_o = out_valid_q;
  assign area_sum_o  = out_sum_q;
  assign frame_end_o = out_end_q;

endmodule
